>>> rtl/audio_peak_meter_hold_fall_assert.svh
// assertion macros for the audio peak meter
`ifndef AUDIO_PEAK_METER_HOLD_FALL_ASSERT_SVH
`define AUDIO_PEAK_METER_HOLD_FALL_ASSERT_SVH
`ifndef SYNTHESIS
`define APM_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) ante |-> cons) else $error(msg);
`define APM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) else $error(msg);
`else
`define APM_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define APM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> rtl/apm_pkg.sv
// types, constants and functions shared by the audio peak meter
`timescale 1ns / 1ps
package apm_pkg;

  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned MANT_BITS_DEF = 6;
  localparam int unsigned LOG_FRAC_BITS = 16;
  localparam int unsigned LEVEL_W       = 12;
  localparam int unsigned LEVEL_SAT     = 1920;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -12'sd1920;

  localparam int unsigned DB_W = 23;
  localparam logic [DB_W-1:0] DB_PER_LOG2 = 23'd6313057;

  localparam int unsigned EL_W       = 16;
  localparam int unsigned RATE_W     = 12;
  localparam int unsigned FALL_W     = RATE_W + EL_W;
  localparam int unsigned DIV_IN_W   = FALL_W - 3;
  localparam int unsigned DIV_MUL_W  = 26;
  localparam logic [DIV_MUL_W-1:0] DIV125_MUL = 26'd34359739;
  localparam int unsigned DIV_PROD_W = DIV_IN_W + DIV_MUL_W;
  localparam int unsigned DIV_SHIFT  = 32;
  localparam int unsigned DROP_W     = DIV_PROD_W - DIV_SHIFT;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD_MS      = 3'd0,
    CFG_FALL_RATE    = 3'd1,
    CFG_FLOOR_LEVEL  = 3'd2,
    CFG_GREEN_LIMIT  = 3'd3,
    CFG_YELLOW_LIMIT = 3'd4,
    CFG_REPAINT_STEP = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ZONE_GREEN  = 2'd0,
    ZONE_YELLOW = 2'd1,
    ZONE_RED    = 2'd2
  } zone_e;

  typedef struct packed {
    logic [15:0]              hold_ms;
    logic [RATE_W-1:0]        fall_rate;
    logic signed [LEVEL_W-1:0] floor_level;
    logic signed [LEVEL_W-1:0] green_limit;
    logic signed [LEVEL_W-1:0] yellow_limit;
    logic [7:0]               repaint_step;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          block_end;
    logic [EL_W-1:0]               elapsed_ms;
  } in_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic signed [LEVEL_W-1:0] held_peak;
    zone_e                     level_zone;
    zone_e                     peak_zone;
    logic                      peak_visible;
    logic                      repaint;
  } out_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] lev;
    logic [DROP_W-1:0]         drop;
    logic [EL_W-1:0]           el;
  } lvl_t;

  // log2 fraction of 1.f by repeated squaring, evaluated at elaboration
  function automatic logic [LOG_FRAC_BITS-1:0] frac_of(input int unsigned f,
                                                       input int unsigned mant);
    logic [63:0]              x;
    logic [LOG_FRAC_BITS-1:0] frac;
    x    = (64'd1 << 30) | (64'(f) << (30 - mant));
    frac = '0;
    for (int i = 0; i < LOG_FRAC_BITS; i++) begin
      x    = (x * x) >> 30;
      frac = {frac[LOG_FRAC_BITS-2:0], 1'b0};
      if (x >= (64'd2 << 30)) begin
        x       = x >> 1;
        frac[0] = 1'b1;
      end
    end
    return frac;
  endfunction

  function automatic zone_e zone_of(input logic signed [LEVEL_W-1:0] v,
                                    input logic signed [LEVEL_W-1:0] green,
                                    input logic signed [LEVEL_W-1:0] yellow);
    if (v < green) begin
      return ZONE_GREEN;
    end
    if (v < yellow) begin
      return ZONE_YELLOW;
    end
    return ZONE_RED;
  endfunction

endpackage

>>> rtl/audio_peak_meter_hold_fall.sv
// top level of the audio peak meter with peak hold and fall
`timescale 1ns / 1ps
// Takes one sample transaction per clock and keeps the running maximum
// magnitude of the current block. The transaction marked block_end closes the
// block: its maximum goes through a five-register pipeline (leading-one
// detect and log table, constant multiply, rounding, then the peak hold
// stage), and one result transaction then leaves the output register, the
// last of the five. Throughput is one sample per cycle unless a block_end
// waits on the level pipeline; log, scale and fall-divide are each pipelined
// so only the peak hold register loops, one block per cycle unless stalled.
// Samples inside a block yield no result and never wait on the result side
// while pipeline stages are free. Configuration writes take effect at once
// and are meant for idle periods only.
`include "audio_peak_meter_hold_fall_assert.svh"
module audio_peak_meter_hold_fall #(
  parameter int unsigned MANT_BITS = apm_pkg::MANT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  apm_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output apm_pkg::out_t                    out_data_o,
  input  logic                             cfg_we_i,
  input  logic [apm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [apm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned SW = apm_pkg::SAMPLE_BITS;

  apm_pkg::cfg_t cfg_q;
  logic          in_v_q;
  apm_pkg::in_t  in_q;
  logic [SW-1:0] block_max_q;

  logic          s1_adv;
  logic [SW-1:0] mag;
  logic [SW-1:0] max_cur;
  logic          lvl_in_ready;
  logic          lvl_valid;
  logic          lvl_ready;
  apm_pkg::lvl_t lvl_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_ms      <= 16'd10000;
      cfg_q.fall_rate    <= 12'd320;
      cfg_q.floor_level  <= -12'sd960;
      cfg_q.green_limit  <= -12'sd320;
      cfg_q.yellow_limit <= -12'sd144;
      cfg_q.repaint_step <= 8'd5;
    end else if (cfg_we_i) begin
      case (apm_pkg::cfg_idx_e'(cfg_idx_i))
        apm_pkg::CFG_HOLD_MS: begin
          cfg_q.hold_ms <= cfg_data_i;
        end
        apm_pkg::CFG_FALL_RATE: begin
          cfg_q.fall_rate <= cfg_data_i[apm_pkg::RATE_W-1:0];
        end
        apm_pkg::CFG_FLOOR_LEVEL: begin
          cfg_q.floor_level <= $signed(cfg_data_i[apm_pkg::LEVEL_W-1:0]);
        end
        apm_pkg::CFG_GREEN_LIMIT: begin
          cfg_q.green_limit <= $signed(cfg_data_i[apm_pkg::LEVEL_W-1:0]);
        end
        apm_pkg::CFG_YELLOW_LIMIT: begin
          cfg_q.yellow_limit <= $signed(cfg_data_i[apm_pkg::LEVEL_W-1:0]);
        end
        apm_pkg::CFG_REPAINT_STEP: begin
          cfg_q.repaint_step <= cfg_data_i[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  // samples inside a block drop out after folding into the maximum
  assign s1_adv     = in_v_q && (!in_q.block_end || lvl_in_ready);
  assign in_ready_o = !in_v_q || s1_adv;

  always_comb begin
    mag     = in_q.sample[SW-1] ? $unsigned(~in_q.sample + 1'b1) : $unsigned(in_q.sample);
    max_cur = (mag > block_max_q) ? mag : block_max_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q      <= 1'b0;
      block_max_q <= '0;
    end else begin
      if (in_ready_o) begin
        in_v_q <= in_valid_i;
      end
      if (s1_adv) begin
        block_max_q <= in_q.block_end ? '0 : max_cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  apm_lvl_pipe #(
    .MANT_BITS (MANT_BITS)
  ) u_lvl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fall_rate_i (cfg_q.fall_rate),
    .in_valid_i  (in_v_q && in_q.block_end),
    .in_ready_o  (lvl_in_ready),
    .m_i         (max_cur),
    .el_i        (in_q.elapsed_ms),
    .out_valid_o (lvl_valid),
    .out_ready_i (lvl_ready),
    .out_data_o  (lvl_data)
  );

  apm_hold u_hold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (lvl_valid),
    .in_ready_o  (lvl_ready),
    .in_data_i   (lvl_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `APM_ASSERT_NEXT(a_max_cleared, clk_i, rst_ni, s1_adv && in_q.block_end, block_max_q == '0, "block maximum not cleared at block end")
  `APM_ASSERT_NEXT(a_max_grows, clk_i, rst_ni, s1_adv && !in_q.block_end, block_max_q >= $past(block_max_q), "block maximum decreased inside a block")
  `APM_ASSERT_SAME(a_stall_holds_item, clk_i, rst_ni, !in_ready_o, in_v_q && in_q.block_end, "input stalled without a pending block end")

endmodule

>>> rtl/apm_lvl_pipe.sv
// level pipeline: block maximum to level in 1/16 dB, plus peak fall amount
`timescale 1ns / 1ps
module apm_lvl_pipe #(
  parameter int unsigned MANT_BITS = apm_pkg::MANT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [apm_pkg::RATE_W-1:0]        fall_rate_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [apm_pkg::SAMPLE_BITS-1:0]   m_i,
  input  logic [apm_pkg::EL_W-1:0]          el_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output apm_pkg::lvl_t                     out_data_o
);

  localparam int unsigned SW    = apm_pkg::SAMPLE_BITS;
  localparam int unsigned PW    = $clog2(SW);
  localparam int unsigned FW    = apm_pkg::LOG_FRAC_BITS;
  localparam int unsigned AW    = PW + FW;
  localparam int unsigned PRW   = AW + apm_pkg::DB_W;
  localparam int unsigned RW    = PRW - 31;
  localparam int unsigned TBL_N = 2 ** MANT_BITS;
  localparam int unsigned LW    = apm_pkg::LEVEL_W;

  logic [FW-1:0] frac_tbl [TBL_N];

  for (genvar g = 0; g < TBL_N; g++) begin : g_frac
    localparam logic [FW-1:0] FracVal = apm_pkg::frac_of(g, MANT_BITS);
    assign frac_tbl[g] = FracVal;
  end

  logic v2_q, v3_q, v4_q, v5_q;
  logic rdy2, rdy3, rdy4, rdy5;

  logic [SW-1:0]                  m_q;
  logic [apm_pkg::EL_W-1:0]       el2_q, el3_q, el4_q, el5_q;
  logic [AW-1:0]                  a_q;
  logic                           zero3_q, zero4_q;
  logic [apm_pkg::FALL_W-1:0]     fp_q;
  logic [PRW-1:0]                 prod_q;
  logic [apm_pkg::DROP_W-1:0]     drop4_q, drop5_q;
  logic signed [LW-1:0]           lev_q;

  logic [PW-1:0]                  p;
  logic [PW-1:0]                  k;
  logic [SW-1:0]                  norm;
  logic [SW+MANT_BITS-1:0]        ext;
  logic [MANT_BITS-1:0]           f;
  logic [AW-1:0]                  a_d;
  logic [apm_pkg::FALL_W-1:0]     fp_d;
  logic [PRW-1:0]                 prod_d;
  logic [apm_pkg::DIV_PROD_W-1:0] dmul;
  logic [PRW:0]                   rsum;
  logic [RW-1:0]                  r;
  logic signed [LW-1:0]           lev_d;

  assign rdy5 = !v5_q || out_ready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign in_ready_o = rdy2;

  // leading one, mantissa and log2 of the block maximum
  always_comb begin
    p = '0;
    for (int i = 0; i < SW; i++) begin
      if (m_q[i]) begin
        p = PW'(i);
      end
    end
    k    = PW'(SW - 1) - p;
    norm = m_q << k;
    ext  = {norm, {MANT_BITS{1'b0}}};
    f    = ext[SW+MANT_BITS-2 -: MANT_BITS];
    a_d  = {k, {FW{1'b0}}} - AW'(frac_tbl[f]);
    fp_d = apm_pkg::FALL_W'(fall_rate_i) * apm_pkg::FALL_W'(el2_q);
  end

  // scale to 1/16 dB; fall amount divided by 1000 as /8 then reciprocal of 125
  always_comb begin
    prod_d = PRW'(a_q) * PRW'(apm_pkg::DB_PER_LOG2);
    dmul   = apm_pkg::DIV_PROD_W'(fp_q[apm_pkg::FALL_W-1:3])
           * apm_pkg::DIV_PROD_W'(apm_pkg::DIV125_MUL);
  end

  // round half away from zero, negate and saturate
  always_comb begin
    rsum = {1'b0, prod_q} + (PRW + 1)'(64'd1 << 31);
    r    = rsum[PRW:32];
    if (zero4_q || (r > RW'(apm_pkg::LEVEL_SAT))) begin
      lev_d = apm_pkg::LEVEL_MIN;
    end else begin
      lev_d = $signed(LW'(0) - LW'(r));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= in_valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
      if (rdy5) begin
        v5_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && in_valid_i) begin
      m_q   <= m_i;
      el2_q <= el_i;
    end
    if (rdy3 && v2_q) begin
      a_q     <= a_d;
      zero3_q <= (m_q == '0);
      fp_q    <= fp_d;
      el3_q   <= el2_q;
    end
    if (rdy4 && v3_q) begin
      prod_q  <= prod_d;
      zero4_q <= zero3_q;
      drop4_q <= dmul[apm_pkg::DIV_PROD_W-1 -: apm_pkg::DROP_W];
      el4_q   <= el3_q;
    end
    if (rdy5 && v4_q) begin
      lev_q   <= lev_d;
      drop5_q <= drop4_q;
      el5_q   <= el4_q;
    end
  end

  assign out_valid_o     = v5_q;
  assign out_data_o.lev  = lev_q;
  assign out_data_o.drop = drop5_q;
  assign out_data_o.el   = el5_q;

endmodule

>>> rtl/apm_hold.sv
// peak hold and fall state, zones, repaint and the result register
`timescale 1ns / 1ps
module apm_hold (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  apm_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  apm_pkg::lvl_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output apm_pkg::out_t out_data_o
);

  localparam int unsigned LW  = apm_pkg::LEVEL_W;
  localparam int unsigned EW  = apm_pkg::EL_W;
  localparam int unsigned NPW = apm_pkg::DROP_W + 2;

  logic                 o_v_q;
  apm_pkg::out_t        o_q;
  logic signed [LW-1:0] peak_q, peak_d;
  logic [EW-1:0]        since_q, since_d;
  logic signed [LW-1:0] last_q, last_d;

  logic                  take;
  logic [EW:0]           since_sum;
  logic [EW-1:0]         since_sat;
  logic signed [NPW-1:0] np;
  logic signed [LW:0]    diff;
  logic [LW:0]           adiff;
  logic                  rep;
  apm_pkg::out_t         o_d;

  assign in_ready_o = !o_v_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    since_sum = {1'b0, since_q} + {1'b0, in_data_i.el};
    since_sat = since_sum[EW] ? '1 : since_sum[EW-1:0];
    np        = NPW'(peak_q) - NPW'($signed({1'b0, in_data_i.drop}));
    peak_d    = peak_q;
    since_d   = since_sat;
    if (in_data_i.lev > peak_q) begin
      peak_d  = in_data_i.lev;
      since_d = '0;
    end else if (since_sat > cfg_i.hold_ms) begin
      peak_d = (np > NPW'(cfg_i.floor_level)) ? np[LW-1:0] : cfg_i.floor_level;
    end

    diff  = (LW + 1)'(in_data_i.lev) - (LW + 1)'(last_q);
    adiff = diff[LW] ? $unsigned(-diff) : $unsigned(diff);
    rep   = adiff >= (LW + 1)'(cfg_i.repaint_step);
    last_d = rep ? in_data_i.lev : last_q;

    o_d.level        = in_data_i.lev;
    o_d.held_peak    = peak_d;
    o_d.level_zone   = apm_pkg::zone_of(in_data_i.lev, cfg_i.green_limit,
                                        cfg_i.yellow_limit);
    o_d.peak_zone    = apm_pkg::zone_of(peak_d, cfg_i.green_limit, cfg_i.yellow_limit);
    o_d.peak_visible = (LW + 1)'(peak_d) > ((LW + 1)'(cfg_i.floor_level) + 13'sd8);
    o_d.repaint      = rep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q   <= 1'b0;
      peak_q  <= -12'sd960;
      since_q <= '0;
      last_q  <= apm_pkg::LEVEL_MIN;
    end else begin
      if (take) begin
        o_v_q   <= 1'b1;
        peak_q  <= peak_d;
        since_q <= since_d;
        last_q  <= last_d;
      end else if (out_ready_i) begin
        o_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      o_q <= o_d;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_data_o  = o_q;

endmodule
